// ===== design/fdt_struct_node_scanner_top_assert.svh =====
// assertion macros used by the walker module
`ifndef FDT_STRUCT_NODE_SCANNER_TOP_ASSERT_SVH
`define FDT_STRUCT_NODE_SCANNER_TOP_ASSERT_SVH

// same-cycle implication
`define FDT_SNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdt_sns assertion failed");

// next-cycle implication
`define FDT_SNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdt_sns assertion failed");

`endif

// ===== design/fdt_sns_pkg.sv =====
// ----------------------------------------------------------------------------
// fdt_sns_pkg
// shared types, token codes and helpers for the structure block scanner
// ----------------------------------------------------------------------------
package fdt_sns_pkg;

  localparam int PREFIX_MAX_DEF = 16;

  localparam logic [31:0] TOKEN_BEGIN    = 32'h0000_0001;
  localparam logic [31:0] TOKEN_END_NODE = 32'h0000_0002;
  localparam logic [31:0] TOKEN_PROP     = 32'h0000_0003;
  localparam logic [31:0] TOKEN_NOP      = 32'h0000_0004;
  localparam logic [31:0] TOKEN_END      = 32'h0000_0009;

  localparam logic [1:0] ST_END_TOKEN = 2'd0;
  localparam logic [1:0] ST_BAD_TOKEN = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [1:0] CFG_SIZE     = 2'd0;
  localparam logic [1:0] CFG_PFX_HI   = 2'd1;
  localparam logic [1:0] CFG_PFX_LO   = 2'd2;
  localparam logic [1:0] CFG_PFX_LEN  = 2'd3;

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    TK_BEGIN, TK_END_NODE, TK_PROP, TK_NOP, TK_END, TK_BAD
  } tok_t;

  typedef enum logic [2:0] {
    MODE_TOKEN, MODE_NAME, MODE_PLEN, MODE_POFF, MODE_DATA
  } mode_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    tok_t        tok;
  } q_entry_t;

  function automatic tok_t classify(logic [31:0] w);
    tok_t t;
    priority if (w == TOKEN_BEGIN)    t = TK_BEGIN;
    else if (w == TOKEN_END_NODE)     t = TK_END_NODE;
    else if (w == TOKEN_PROP)         t = TK_PROP;
    else if (w == TOKEN_NOP)          t = TK_NOP;
    else if (w == TOKEN_END)          t = TK_END;
    else                              t = TK_BAD;
    return t;
  endfunction

  function automatic logic [7:0] prefix_char(logic [127:0] pfx, logic [4:0] p);
    logic [127:0] sh;
    sh = pfx << {p[3:0], 3'b000};
    return p[4] ? 8'h00 : sh[127:120];
  endfunction

endpackage

// ===== design/fdt_sns_front.sv =====
// ----------------------------------------------------------------------------
// fdt_sns_front
// accepts structure words, classifies tokens, two-entry queue to the walker
// ----------------------------------------------------------------------------
module fdt_sns_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_struct_word,
  input  logic                  in_last_word,
  output logic                  q_valid,
  output fdt_sns_pkg::q_entry_t q_data,
  input  logic                  q_pop
);
  import fdt_sns_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{word: in_struct_word, last: in_last_word,
                           tok: classify(in_struct_word)};
    end
  end

endmodule

// ===== design/fdt_sns_walk.sv =====
// ----------------------------------------------------------------------------
// fdt_sns_walk
// walks tokens, names and property skips; holds config and the result register
// ----------------------------------------------------------------------------
module fdt_sns_walk #(
  parameter int PREFIX_MAX = fdt_sns_pkg::PREFIX_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_wdata,
  input  logic                  q_valid,
  input  fdt_sns_pkg::q_entry_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [30:0]           out_node_count,
  output logic [63:0]           out_min_unit_addr,
  output logic [31:0]           out_first_match_offset,
  output logic [1:0]            out_end_status
);
  import fdt_sns_pkg::*;

  logic [31:0]  size_r;
  logic [127:0] pfx_r;
  logic [4:0]   pfx_len_r;
  logic [4:0]   elen;

  mode_t        mode_r, mode_nxt;
  logic [7:0]   depth_r, depth_nxt;
  logic [31:0]  off_r, off_nxt;
  logic [29:0]  skip_r, skip_nxt;
  logic [4:0]   pos_r, pos_nxt;
  logic [2:0]   flags_r, flags_nxt;   // mismatch, at, hexstop
  logic [63:0]  acc_r, acc_nxt;
  logic [30:0]  cnt_r, cnt_nxt;
  logic [63:0]  low_r, low_nxt;
  logic [31:0]  first_r, first_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [30:0]  res_cnt_r;
  logic [63:0]  res_low_r;
  logic [31:0]  res_first_r;
  logic [1:0]   res_st_r;

  logic         fire, fin;
  logic [1:0]   st;
  logic [31:0]  after;
  logic [31:0]  plen_sum;

  assign elen  = (pfx_len_r > 5'(PREFIX_MAX)) ? 5'(PREFIX_MAX) : pfx_len_r;
  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;
  assign after = off_r + 32'd4;
  assign plen_sum = q_data.word + 32'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= '0;
      pfx_r     <= '0;
      pfx_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE:    size_r          <= cfg_wdata[31:0];
        CFG_PFX_HI:  pfx_r[127:64]   <= cfg_wdata;
        CFG_PFX_LO:  pfx_r[63:0]     <= cfg_wdata;
        CFG_PFX_LEN: pfx_len_r       <= cfg_wdata[4:0];
        default:     size_r          <= size_r;
      endcase
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       stop;
    logic       done;
    logic [7:0] pc;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    off_nxt   = off_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    low_nxt   = low_r;
    first_nxt = first_r;
    fin       = 1'b0;
    st        = ST_EXHAUSTED;
    stop      = 1'b0;
    done      = 1'b0;
    c         = 8'h00;
    pc        = 8'h00;
    if (fire) begin
      if (mode_r == MODE_TOKEN && off_r >= size_r) begin
        fin = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_TOKEN: begin
            unique case (q_data.tok)
              TK_BEGIN: begin
                if (depth_r != 8'hFF) depth_nxt = depth_r + 8'd1;
                pos_nxt   = '0;
                flags_nxt = '0;
                acc_nxt   = '0;
                mode_nxt  = MODE_NAME;
              end
              TK_END_NODE: begin
                if (depth_r != 8'h00) depth_nxt = depth_r - 8'd1;
              end
              TK_PROP: mode_nxt = MODE_PLEN;
              TK_NOP:  mode_nxt = MODE_TOKEN;
              TK_END: begin
                fin = 1'b1;
                st  = ST_END_TOKEN;
              end
              default: begin
                fin = 1'b1;
                st  = ST_BAD_TOKEN;
              end
            endcase
          end
          MODE_NAME: begin
            for (int i = 0; i < 4; i++) begin
              c = q_data.word[31-8*i -: 8];
              if (!stop) begin
                if (c == 8'h00) begin
                  stop = 1'b1;
                  done = (pos_nxt >= elen) || (prefix_char(pfx_r, pos_nxt) == 8'h00);
                  if (depth_r == 8'd2 && !flags_nxt[0] && done) begin
                    if (cnt_nxt == '0) first_nxt = after;
                    if (cnt_nxt != COUNT_MAX) cnt_nxt = cnt_nxt + 31'd1;
                    if (flags_nxt[1] && acc_nxt < low_nxt) low_nxt = acc_nxt;
                  end
                end else begin
                  if (!flags_nxt[0] && pos_nxt < elen) begin
                    pc = prefix_char(pfx_r, pos_nxt);
                    if (pc != 8'h00) begin
                      if (c != pc) flags_nxt[0] = 1'b1;
                      else         pos_nxt = pos_nxt + 5'd1;
                    end
                  end
                  if (flags_nxt[1]) begin
                    if (!flags_nxt[2]) begin
                      if (c >= 8'h30 && c <= 8'h39)
                        acc_nxt = {acc_nxt[59:0], c[3:0]};
                      else if (c >= 8'h61 && c <= 8'h66)
                        acc_nxt = {acc_nxt[59:0], 4'(c - 8'h57)};
                      else
                        flags_nxt[2] = 1'b1;
                    end
                  end else if (c == 8'h40) begin
                    flags_nxt[1] = 1'b1;
                  end
                end
              end
            end
            if (stop) mode_nxt = MODE_TOKEN;
          end
          MODE_PLEN: begin
            skip_nxt = plen_sum[31:2];
            mode_nxt = MODE_POFF;
          end
          MODE_POFF: mode_nxt = (skip_r != '0) ? MODE_DATA : MODE_TOKEN;
          default: begin
            if (skip_r != '0) skip_nxt = skip_r - 30'd1;
            if (skip_nxt == '0) mode_nxt = MODE_TOKEN;
          end
        endcase
        off_nxt = after;
        if (!fin && ((mode_nxt == MODE_TOKEN && after >= size_r) || q_data.last)) begin
          fin = 1'b1;
          st  = ST_EXHAUSTED;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && fin)      out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && fin)) begin
      mode_r  <= MODE_TOKEN;
      depth_r <= '0;
      off_r   <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      flags_r <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      low_r   <= '1;
      first_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      off_r   <= off_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      low_r   <= low_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire && fin) begin
      res_cnt_r   <= cnt_nxt;
      res_low_r   <= low_nxt;
      res_first_r <= first_nxt;
      res_st_r    <= st;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_node_count         = res_cnt_r;
  assign out_min_unit_addr      = res_low_r;
  assign out_first_match_offset = res_first_r;
  assign out_end_status         = res_st_r;

`include "fdt_struct_node_scanner_top_assert.svh"

  `FDT_SNS_ASSERT_NEXT(a_fin_shows_result, fire && fin, out_valid_r)
  `FDT_SNS_ASSERT_NOW(a_held_result_blocks, out_valid_r && out_stall, !fire)
  `FDT_SNS_ASSERT_NEXT(a_fin_clears_walk, fire && fin, mode_r == MODE_TOKEN && off_r == '0)

endmodule

// ===== design/fdt_struct_node_scanner_top.sv =====
// ----------------------------------------------------------------------------
// fdt_struct_node_scanner_top
// device-tree structure block walker: counts prefixed depth-two nodes
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_      | in  | in_valid/in_stall  | struct_word, last_word
//  out_     | out | out_valid/out_stall| node_count, min_unit_addr, first_match_offset,
//           |     |                    | end_status
//  cfg_     | in  | cfg_we             | cfg_index, cfg_wdata
//
//  one word per cycle sustained; the walker takes a word each cycle the result
//  register is free, a whole name word (four bytes) handled in that cycle
//  a result follows its last word through the queue, then the result register
//  two-entry queue between classifier and walker; out_stall holds the result
//  and backs up into in_stall once the queue fills
//  rst_n synchronous, clears walk state and config registers
module fdt_struct_node_scanner_top #(
  parameter int PREFIX_MAX = fdt_sns_pkg::PREFIX_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_struct_word,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_node_count,
  output logic [63:0] out_min_unit_addr,
  output logic [31:0] out_first_match_offset,
  output logic [1:0]  out_end_status
);
  import fdt_sns_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_data;

  fdt_sns_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_struct_word (in_struct_word),
    .in_last_word   (in_last_word),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop)
  );

  fdt_sns_walk #(.PREFIX_MAX(PREFIX_MAX)) u_walk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .q_valid                (q_valid),
    .q_data                 (q_data),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_node_count         (out_node_count),
    .out_min_unit_addr      (out_min_unit_addr),
    .out_first_match_offset (out_first_match_offset),
    .out_end_status         (out_end_status)
  );

endmodule

// ===== tb/sv/tb_fdt_struct_node_scanner_top.sv =====
// ----------------------------------------------------------------------------
// tb_fdt_struct_node_scanner_top
// Regression for the device-tree structure block scanner. A built-in walk
// predictor tracks tokens, depth, name bytes and skipped property words for
// every accepted word and produces the expected end-of-walk summary when a
// walk ends. Directed walks cover the token set, size and depth limits and
// prefix corner cases. Random well-formed trees with noise follow, under
// several settings, with random gaps on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_fdt_struct_node_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdt_sns_pkg::*;

  typedef struct packed {
    bit [30:0] count;
    bit [63:0] base;
    bit [31:0] offset;
    bit [1:0]  status;
  } scan_sum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SIZE;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_struct_word = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] out_node_count;
  logic [63:0] out_min_unit_addr;
  logic [31:0] out_first_match_offset;
  logic [1:0]  out_end_status;

  fdt_struct_node_scanner_top dut (.*);

  // scanner registers and walk state as predicted
  bit [31:0]  r_size;
  bit [127:0] r_pfx;
  bit [4:0]   r_len;
  mode_t      w_mode;
  int         w_depth;
  bit [31:0]  w_off, w_skip, w_foff;
  bit [4:0]   w_ppos;
  bit         f_mism, f_at, f_hexstop;
  bit [63:0]  w_acc, w_low;
  bit [30:0]  w_count;
  bit         walk_open;

  scan_sum_t  summary_q[$];
  bit [31:0]  stream[$];
  byte unsigned nm[$];
  string      cur_pfx;
  int         items_sent;
  int         mismatches;
  bit         idle_on = 1'b1;

  initial forever #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("fdt_struct_node_scanner_top regression: fail");
    $finish;
  end

  always @(posedge clk) out_stall <= idle_on && rst_n && ($urandom_range(99) < 21);

  function automatic void clear_walk();
    w_mode = MODE_TOKEN;
    w_depth = 0;
    w_off = 0;
    w_skip = 0;
    w_ppos = 0;
    {f_mism, f_at, f_hexstop} = '0;
    w_acc = 0;
    w_count = 0;
    w_low = '1;
    w_foff = 0;
  endfunction

  function automatic bit [7:0] pfx_char(bit [4:0] p);
    if (p < 16) return r_pfx[127 - 8 * p -: 8];
    return 8'h00;
  endfunction

  function automatic void wrap_up(output scan_sum_t r, input bit [1:0] status);
    r.count = w_count;
    r.base = w_low;
    r.offset = w_foff;
    r.status = status;
    clear_walk();
  endfunction

  function automatic bit name_byte(bit [7:0] c, bit [31:0] off_after);
    bit [4:0] len;
    bit [7:0] pc;
    bit done;
    len = (r_len > 16) ? 5'd16 : r_len;
    if (c == 0) begin
      done = (w_ppos >= len) || (pfx_char(w_ppos) == 0);
      if (w_depth == 2 && !f_mism && done) begin
        if (w_count == 0) w_foff = off_after;
        if (w_count != COUNT_MAX) w_count++;
        if (f_at && w_acc < w_low) w_low = w_acc;
      end
      return 1'b1;
    end
    if (!f_mism && w_ppos < len) begin
      pc = pfx_char(w_ppos);
      if (pc != 0) begin
        if (c != pc) f_mism = 1'b1;
        else w_ppos++;
      end
    end
    if (f_at) begin
      if (!f_hexstop) begin
        if (c >= "0" && c <= "9") w_acc = {w_acc[59:0], 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f") w_acc = {w_acc[59:0], 4'(c - 8'h57)};
        else f_hexstop = 1'b1;
      end
    end else if (c == "@") begin
      f_at = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit scan_word(bit [31:0] w, bit last, output scan_sum_t r);
    bit [31:0] after;
    bit [31:0] t;
    after = w_off + 32'd4;
    if (w_mode == MODE_TOKEN && w_off >= r_size) begin
      wrap_up(r, ST_EXHAUSTED);
      return 1'b1;
    end
    case (w_mode)
      MODE_TOKEN: begin
        if (w == TOKEN_BEGIN) begin
          if (w_depth < 255) w_depth++;
          w_ppos = 0;
          {f_mism, f_at, f_hexstop} = '0;
          w_acc = 0;
          w_mode = MODE_NAME;
        end else if (w == TOKEN_END_NODE) begin
          if (w_depth > 0) w_depth--;
        end else if (w == TOKEN_PROP) begin
          w_mode = MODE_PLEN;
        end else if (w == TOKEN_NOP) begin
        end else if (w == TOKEN_END) begin
          wrap_up(r, ST_END_TOKEN);
          return 1'b1;
        end else begin
          wrap_up(r, ST_BAD_TOKEN);
          return 1'b1;
        end
      end
      MODE_NAME: begin
        for (int i = 0; i < 4; i++) begin
          if (name_byte(w[31 - 8 * i -: 8], after)) begin
            w_mode = MODE_TOKEN;
            break;
          end
        end
      end
      MODE_PLEN: begin
        t = w + 32'd3;
        w_skip = t >> 2;
        w_mode = MODE_POFF;
      end
      MODE_POFF: w_mode = (w_skip != 0) ? MODE_DATA : MODE_TOKEN;
      default: begin
        if (w_skip > 0) w_skip--;
        if (w_skip == 0) w_mode = MODE_TOKEN;
      end
    endcase
    w_off = after;
    if ((w_mode == MODE_TOKEN && w_off >= r_size) || last) begin
      wrap_up(r, ST_EXHAUSTED);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // result checking
  initial forever begin
    scan_sum_t got, want;
    @(negedge clk);
    if (rst_n && out_valid && !out_stall) begin
      got.count = out_node_count;
      got.base = out_min_unit_addr;
      got.offset = out_first_match_offset;
      got.status = out_end_status;
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: count %0d base %h off %h status %0d",
                                       got.count, got.base, got.offset, got.status);
      end else begin
        want = summary_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp count %0d base %h off %h status %0d, got %0d %h %h %0d",
                     want.count, want.base, want.offset, want.status,
                     got.count, got.base, got.offset, got.status);
        end
      end
    end
  end

  task automatic send_word(input bit [31:0] w, input bit last, output bit done);
    bit acc;
    scan_sum_t r;
    if (idle_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_struct_word <= w;
    in_last_word <= last;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    items_sent++;
    done = scan_word(w, last, r);
    if (done) summary_q.push_back(r);
    walk_open = !done;
  endtask

  // close any open walk and drain before touching registers
  task automatic settle();
    bit d;
    if (walk_open) send_word(TOKEN_NOP, 1'b1, d);
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input bit [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SIZE:   r_size = data[31:0];
      CFG_PFX_HI: r_pfx[127:64] = data;
      CFG_PFX_LO: r_pfx[63:0] = data;
      default:    r_len = data[4:0];
    endcase
  endtask

  task automatic set_config(input bit [31:0] size, input string s, input bit [4:0] len);
    bit [127:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < 16; i++) p[127 - 8 * i -: 8] = s[i];
    cur_pfx = s;
    settle();
    cfg_write(CFG_SIZE, {32'h0, size});
    cfg_write(CFG_PFX_HI, p[127:64]);
    cfg_write(CFG_PFX_LO, p[63:0]);
    cfg_write(CFG_PFX_LEN, {59'h0, len});
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
  endfunction

  function automatic void put_name();
    bit [31:0] w;
    nm.push_back(8'h00);
    while (nm.size() % 4 != 0) nm.push_back(8'h00);
    for (int i = 0; i < nm.size(); i += 4) begin
      w = {nm[i], nm[i + 1], nm[i + 2], nm[i + 3]};
      stream.push_back(w);
    end
    nm.delete();
  endfunction

  function automatic void put_prop(bit [31:0] len);
    bit [31:0] n;
    n = (len + 32'd3) >> 2;
    stream.push_back(TOKEN_PROP);
    stream.push_back(len);
    stream.push_back($urandom);
    repeat (n) stream.push_back($urandom);
  endfunction

  function automatic byte unsigned hex_char();
    int d;
    d = $urandom_range(15);
    return (d < 10) ? byte'(8'h30 + d) : byte'(8'h57 + d);
  endfunction

  function automatic void gen_name(int d);
    int n;
    if (d == 2 && $urandom_range(9) < 6) begin
      add_str(cur_pfx);
      if ($urandom_range(9) < 3) nm.push_back(byte'($urandom_range(8'h61, 8'h7a)));
      if ($urandom_range(9) < 7) begin
        nm.push_back("@");
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 10);
        repeat (n) nm.push_back(hex_char());
        if ($urandom_range(9) == 0) begin
          nm.push_back("G");
          nm.push_back(hex_char());
        end
      end
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(3))
          0: nm.push_back(byte'($urandom_range(1, 255)));
          1: nm.push_back("@");
          2: nm.push_back(hex_char());
          default: nm.push_back(byte'($urandom_range(8'h61, 8'h7a)));
        endcase
      end
    end
    put_name();
  endfunction

  function automatic void gen_node(int d);
    int kids;
    stream.push_back(TOKEN_BEGIN);
    gen_name(d);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(3) == 0) stream.push_back(TOKEN_NOP);
      put_prop(($urandom_range(19) == 0) ? $urandom_range(32'hFFFF_FFFD, 32'hFFFF_FFFF)
                                         : $urandom_range(0, 16));
    end
    kids = (d == 1) ? $urandom_range(1, 5) : (d < 4 ? $urandom_range(0, 1) : 0);
    repeat (kids) gen_node(d + 1);
    stream.push_back(TOKEN_END_NODE);
  endfunction

  task automatic play(input bit stop, input bit rnd_last);
    bit done, lst;
    for (int i = 0; i < stream.size(); i++) begin
      lst = rnd_last && ((i == stream.size() - 1) ? $urandom_range(1) : ($urandom_range(99) < 2));
      send_word(stream[i], lst, done);
      if (done && stop) break;
    end
    stream.delete();
  endtask

  task automatic test_reset_defaults();
    bit d;
    send_word(TOKEN_BEGIN, 1'b0, d);
    send_word(TOKEN_END, 1'b1, d);
    send_word(32'hFFFF_FFFF, 1'b0, d);
    send_word(32'h0000_0000, 1'b0, d);
  endtask

  task automatic test_tokens();
    set_config(32'hFFFF_FFFF, "cpu", 5'd3);
    stream.push_back(TOKEN_BEGIN);
    put_name();
    put_prop(32'd5);
    stream.push_back(TOKEN_BEGIN);
    add_str("cpu@1f");
    put_name();
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_BEGIN);
    add_str("cpu@");
    put_name();
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_BEGIN);
    add_str("cp");
    put_name();
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_NOP);
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_END);
    stream.push_back(32'hDEAD_BEEF);
    put_prop(32'hFFFF_FFFF);
    put_prop(32'h0);
    stream.push_back(TOKEN_END);
    play(1'b0, 1'b0);
  endtask

  task automatic test_size_edges();
    bit d;
    set_config(32'd6, "abc", 5'd3);
    stream.push_back(TOKEN_BEGIN);
    add_str("abcdefgh");
    put_name();
    play(1'b0, 1'b0);
    set_config(32'd0, "abc", 5'd3);
    send_word(TOKEN_NOP, 1'b0, d);
    set_config(32'd12, "", 5'd0);
    send_word(TOKEN_NOP, 1'b0, d);
    send_word(TOKEN_NOP, 1'b1, d);
  endtask

  task automatic test_prefix_edges();
    set_config(32'hFFFF_FFFF, "abcdefghijklmnop", 5'd31);
    stream.push_back(TOKEN_BEGIN);
    put_name();
    stream.push_back(TOKEN_BEGIN);
    add_str("abcdefghijklmnopq@ffffffffffffffff1");
    put_name();
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_END);
    play(1'b0, 1'b0);
    set_config(32'hFFFF_FFFF, "a", 5'd16);
    stream.push_back(TOKEN_BEGIN);
    put_name();
    stream.push_back(TOKEN_BEGIN);
    add_str("ax@7");
    put_name();
    stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_END);
    play(1'b0, 1'b0);
  endtask

  task automatic test_depth_limit();
    set_config(32'hFFFF_FFFF, "", 5'd0);
    repeat (258) begin
      stream.push_back(TOKEN_BEGIN);
      put_name();
    end
    repeat (253) stream.push_back(TOKEN_END_NODE);
    stream.push_back(TOKEN_BEGIN);
    add_str("n@5");
    put_name();
    stream.push_back(TOKEN_END);
    play(1'b0, 1'b0);
  endtask

  task automatic test_random_walks();
    string pfx_set[8];
    string s;
    bit [31:0] size;
    int phase;
    pfx_set = '{"cpu", "memory", "serial", "uart", "", "intc", "abcdefghijklmnop", "pci"};
    phase = 0;
    while (items_sent < 1550) begin
      s = pfx_set[$urandom_range(7)];
      case ($urandom_range(9))
        0: size = 32'd0;
        1, 2: size = $urandom_range(0, 200);
        3: size = $urandom_range(0, 50) * 4;
        default: size = 32'hFFFF_FFFF;
      endcase
      set_config(size, s, ($urandom_range(4) == 0) ? 5'($urandom_range(0, 31)) : 5'(s.len()));
      idle_on = (phase != 2);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 8))
            stream.push_back(($urandom_range(1) == 1) ? $urandom : $urandom_range(0, 10));
        end else begin
          gen_node(1);
          if ($urandom_range(9) == 0) stream.push_back(TOKEN_END_NODE);
          stream.push_back(TOKEN_END);
          if ($urandom_range(99) < 8) stream[$urandom_range(stream.size() - 1)] = $urandom;
          if ($urandom_range(99) < 5)
            stream[$urandom_range(stream.size() - 1)] = $urandom_range(5, 8);
        end
        play(1'b1, 1'b1);
      end
      idle_on = 1'b1;
      phase++;
    end
  endtask

  initial begin
    r_size = 0;
    r_pfx = 0;
    r_len = 0;
    clear_walk();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_tokens();
    test_size_edges();
    test_prefix_edges();
    test_depth_limit();
    test_random_walks();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("fdt_struct_node_scanner_top regression: pass");
    end else begin
      $display("fdt_struct_node_scanner_top regression: fail");
    end
    $finish;
  end

endmodule
